FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

FILE: rtl/core/stdts_pkg.sv
`timescale 1ns / 1ps

package stdts_pkg;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [15:0] speed_sample;
		logic               read_ok;
	} item_t;

	typedef struct packed {
		logic               torque_write;
		logic signed [11:0] torque;
		logic [1:0]         mode_now;
	} result_t;

	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_NORMAL = 2'd1;
	localparam logic [1:0] CMD_SHAKE  = 2'd2;
	localparam logic [1:0] CMD_DAMP   = 2'd3;

	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_SHAKE  = 2'd1;
	localparam logic [1:0] MODE_DAMP   = 2'd2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SHAKE_CURRENT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CYCLE_COUNT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DAMP_LIMIT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DAMP_GAIN     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_ALPHA   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TORQUE_ALPHA  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND      = 3'd7;

	localparam logic [10:0] RST_SHAKE_CURRENT = 11'd800;
	localparam logic [9:0]  RST_HALF_PERIOD   = 10'd80;
	localparam logic [4:0]  RST_CYCLE_COUNT   = 5'd3;
	localparam logic [10:0] RST_DAMP_LIMIT    = 11'd1200;
	localparam logic [15:0] RST_DAMP_GAIN     = 16'd1536;
	localparam logic [8:0]  RST_SPEED_ALPHA   = 9'd90;
	localparam logic [8:0]  RST_TORQUE_ALPHA  = 9'd38;
	localparam logic [9:0]  RST_DEADBAND      = 10'd48;

	localparam logic [9:0]  HALF_MIN  = 10'd20;
	localparam logic [9:0]  HALF_MAX  = 10'd1000;
	localparam logic [4:0]  CYC_MIN   = 5'd1;
	localparam logic [4:0]  CYC_MAX   = 5'd20;
	localparam logic [15:0] GAIN_MAX  = 16'd51200;
	localparam logic [8:0]  ALPHA_MIN = 9'd3;
	localparam logic [8:0]  ALPHA_ONE = 9'd256;
	localparam logic [9:0]  BAND_MAX  = 10'd800;

endpackage

FILE: rtl/core/shake_then_damping_torque_sequencer_core.sv
// channel   direction  handshake                 payload
// item      in         item_valid/item_stall     item_t (command, speed_sample, read_ok)
// result    out        result_valid/result_stall result_t (torque_write, torque, mode_now)
// cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// A damping tick with a good read makes, from acceptance to a valid result,
// five passes through the shared 24x17 multiplier, two filter adds, a clamp and output.
// A shake tick takes a wrap step, repeated while a half period ends; others skip to output.
// item_stall is high from acceptance until the result is loaded into the output
// register; a stalled result holds the block in its final step.
// Reset clears mode, counters, filters and restores the register defaults.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module shake_then_damping_torque_sequencer_core
	import stdts_pkg::*;
#(
	parameter int TICK_MS           = 10,
	parameter int TORQUE_HARD_LIMIT = 2000
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_WRAP = 4'd1;
	localparam logic [3:0] ST_SM1  = 4'd2;
	localparam logic [3:0] ST_SM2  = 4'd3;
	localparam logic [3:0] ST_SF   = 4'd4;
	localparam logic [3:0] ST_GM   = 4'd5;
	localparam logic [3:0] ST_RAW  = 4'd6;
	localparam logic [3:0] ST_TM1  = 4'd7;
	localparam logic [3:0] ST_TM2  = 4'd8;
	localparam logic [3:0] ST_TF   = 4'd9;
	localparam logic [3:0] ST_OUT  = 4'd10;
	localparam logic [3:0] ST_DONE = 4'd11;

	logic [3:0] state_q;
	logic [1:0] mode_q;
	logic [9:0] ms_q;
	logic [5:0] hc_q;
	logic signed [23:0] fs_q;
	logic signed [17:0] ft_q;
	logic result_valid_q;
	result_t result_q;
	result_t pend_q;
	logic signed [15:0] x_q;
	logic signed [40:0] prod_q;
	logic signed [40:0] acc_q;
	logic signed [17:0] raw_q;
	logic dead_q;

	logic [10:0] shake_cur_q;
	logic [9:0]  half_q;
	logic [4:0]  cyc_q;
	logic [10:0] lim_q;
	logic [15:0] gain_q;
	logic [8:0]  sa_q;
	logic [8:0]  ta_q;
	logic [9:0]  band_q;

	logic [10:0] shake_c;
	logic [9:0]  half_c;
	logic [4:0]  cyc_c;
	logic [10:0] lim_c;
	logic [15:0] gain_c;
	logic [8:0]  sa_c;
	logic [8:0]  ta_c;
	logic [9:0]  band_c;

	logic accept;
	logic cfg_wr;
	logic load_res;

	result_t dec_pend;
	logic [1:0] dec_mode;
	logic dec_clear;
	logic dec_shake;
	logic dec_run;

	logic signed [11:0] shake_s;
	logic signed [11:0] lim_s;
	logic [5:0] cyc2;
	logic [9:0] ms_sum;
	logic ms_wrap;

	logic signed [23:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [40:0] mul_p;
	logic signed [41:0] filt_sum;
	logic signed [41:0] raw_t;
	logic signed [27:0] raw_sh;
	logic signed [27:0] lim64_s;
	logic signed [27:0] nlim64_s;
	logic signed [17:0] raw_clamp;
	logic [24:0] fs_mag;
	logic dead_d;
	logic signed [17:0] ft_adj;
	logic signed [11:0] out_div;
	logic signed [11:0] out_clamp;

	logic res_shake_oob;
	logic res_damp_oob;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);
	assign cfg_ready  = (state_q == ST_IDLE);
	assign cfg_wr     = cfg_valid && cfg_ready;
	assign load_res   = (state_q == ST_DONE) && (!result_valid_q || !result_stall);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		shake_c = (32'(shake_cur_q) > 32'(TORQUE_HARD_LIMIT)) ?
			11'(TORQUE_HARD_LIMIT) : shake_cur_q;
		lim_c = (32'(lim_q) > 32'(TORQUE_HARD_LIMIT)) ? 11'(TORQUE_HARD_LIMIT) : lim_q;
		half_c = (half_q < HALF_MIN) ? HALF_MIN : ((half_q > HALF_MAX) ? HALF_MAX : half_q);
		cyc_c = (cyc_q < CYC_MIN) ? CYC_MIN : ((cyc_q > CYC_MAX) ? CYC_MAX : cyc_q);
		gain_c = (gain_q > GAIN_MAX) ? GAIN_MAX : gain_q;
		sa_c = (sa_q < ALPHA_MIN) ? ALPHA_MIN : ((sa_q > ALPHA_ONE) ? ALPHA_ONE : sa_q);
		ta_c = (ta_q < ALPHA_MIN) ? ALPHA_MIN : ((ta_q > ALPHA_ONE) ? ALPHA_ONE : ta_q);
		band_c = (band_q > BAND_MAX) ? BAND_MAX : band_q;
	end

	assign shake_s = {1'b0, shake_c};
	assign lim_s   = {1'b0, lim_c};
	assign cyc2    = {cyc_c, 1'b0};
	assign ms_sum  = ms_q + 10'(TICK_MS);
	assign ms_wrap = (ms_q >= half_c);

	always_comb begin
		dec_pend.torque_write = 1'b0;
		dec_pend.torque       = '0;
		dec_mode  = mode_q;
		dec_clear = 1'b0;
		dec_shake = 1'b0;
		dec_run   = 1'b0;
		unique case (item.command)
			CMD_NORMAL: begin
				dec_mode = MODE_NORMAL;
				dec_clear = 1'b1;
				dec_pend.torque_write = 1'b1;
			end
			CMD_SHAKE: begin
				dec_mode = MODE_SHAKE;
				dec_clear = 1'b1;
			end
			CMD_DAMP: begin
				dec_mode = MODE_DAMP;
				dec_clear = 1'b1;
			end
			CMD_TICK: begin
				unique case (mode_q)
					MODE_NORMAL: begin
						dec_mode = MODE_NORMAL;
					end
					MODE_SHAKE: begin
						dec_pend.torque_write = 1'b1;
						if (hc_q >= cyc2) begin
							dec_mode = MODE_DAMP;
							dec_clear = 1'b1;
						end else begin
							dec_shake = 1'b1;
							dec_pend.torque = hc_q[0] ? -shake_s : shake_s;
						end
					end
					MODE_DAMP: begin
						dec_pend.torque_write = 1'b1;
						dec_run = item.read_ok;
					end
					default: begin
						dec_mode = MODE_NORMAL;
						dec_clear = 1'b1;
					end
				endcase
			end
		endcase
		dec_pend.mode_now = dec_mode;
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SM1: begin
				mul_a = 24'(x_q);
				mul_b = {8'b0, sa_c};
			end
			ST_SM2: begin
				mul_a = fs_q;
				mul_b = {8'b0, 9'(ALPHA_ONE - sa_c)};
			end
			ST_GM: begin
				mul_a = fs_q;
				mul_b = {1'b0, gain_c};
			end
			ST_TM1: begin
				mul_a = 24'(raw_q);
				mul_b = {8'b0, ta_c};
			end
			ST_TM2: begin
				mul_a = 24'(ft_q);
				mul_b = {8'b0, 9'(ALPHA_ONE - ta_c)};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p    = mul_a * mul_b;
	assign filt_sum = 42'(acc_q) + 42'(prod_q) + 42'sd128;

	assign raw_t    = 42'sd8192 - 42'(prod_q);
	assign raw_sh   = raw_t[41:14];
	assign lim64_s  = {11'b0, lim_c, 6'b0};
	assign nlim64_s = -lim64_s;

	always_comb begin
		priority if (raw_sh > lim64_s) begin
			raw_clamp = lim64_s[17:0];
		end else if (raw_sh < nlim64_s) begin
			raw_clamp = nlim64_s[17:0];
		end else begin
			raw_clamp = raw_sh[17:0];
		end
	end

	assign fs_mag = fs_q[23] ? -{fs_q[23], fs_q} : {fs_q[23], fs_q};
	assign dead_d = (fs_mag < {7'b0, band_c, 8'b0});

	assign ft_adj  = ft_q + (ft_q[17] ? 18'sd63 : 18'sd0);
	assign out_div = ft_adj[17:6];

	always_comb begin
		priority if (out_div > lim_s) begin
			out_clamp = lim_s;
		end else if (out_div < -lim_s) begin
			out_clamp = -lim_s;
		end else begin
			out_clamp = out_div;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			mode_q         <= MODE_NORMAL;
			ms_q           <= '0;
			hc_q           <= '0;
			fs_q           <= '0;
			ft_q           <= '0;
			result_valid_q <= 1'b0;
			shake_cur_q    <= RST_SHAKE_CURRENT;
			half_q         <= RST_HALF_PERIOD;
			cyc_q          <= RST_CYCLE_COUNT;
			lim_q          <= RST_DAMP_LIMIT;
			gain_q         <= RST_DAMP_GAIN;
			sa_q           <= RST_SPEED_ALPHA;
			ta_q           <= RST_TORQUE_ALPHA;
			band_q         <= RST_DEADBAND;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				unique case (cfg_index)
					REG_SHAKE_CURRENT: shake_cur_q <= cfg_data[10:0];
					REG_HALF_PERIOD:   half_q      <= cfg_data[9:0];
					REG_CYCLE_COUNT:   cyc_q       <= cfg_data[4:0];
					REG_DAMP_LIMIT:    lim_q       <= cfg_data[10:0];
					REG_DAMP_GAIN:     gain_q      <= cfg_data;
					REG_SPEED_ALPHA:   sa_q        <= cfg_data[8:0];
					REG_TORQUE_ALPHA:  ta_q        <= cfg_data[8:0];
					REG_DEADBAND:      band_q      <= cfg_data[9:0];
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q <= dec_mode;
						if (dec_clear) begin
							ms_q <= '0;
							hc_q <= '0;
							fs_q <= '0;
							ft_q <= '0;
						end
						if (dec_shake) begin
							ms_q    <= ms_sum;
							state_q <= ST_WRAP;
						end else if (dec_run) begin
							state_q <= ST_SM1;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_WRAP: begin
					if (ms_wrap) begin
						ms_q <= ms_q - half_c;
						hc_q <= hc_q + 6'd1;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SM1: state_q <= ST_SM2;
				ST_SM2: state_q <= ST_SF;
				ST_SF: begin
					fs_q    <= filt_sum[31:8];
					state_q <= ST_GM;
				end
				ST_GM: state_q <= ST_RAW;
				ST_RAW: begin
					if (dead_q) begin
						ft_q <= '0;
					end
					state_q <= ST_TM1;
				end
				ST_TM1: state_q <= ST_TM2;
				ST_TM2: state_q <= ST_TF;
				ST_TF: begin
					ft_q    <= filt_sum[25:8];
					state_q <= ST_OUT;
				end
				ST_OUT: state_q <= ST_DONE;
				ST_DONE: begin
					if (load_res) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					pend_q <= dec_pend;
					x_q    <= item.speed_sample;
				end
			end
			ST_SM1: prod_q <= mul_p;
			ST_SM2: begin
				acc_q  <= prod_q <<< 8;
				prod_q <= mul_p;
			end
			ST_GM: begin
				prod_q <= mul_p;
				dead_q <= dead_d;
			end
			ST_RAW: raw_q <= dead_q ? '0 : raw_clamp;
			ST_TM1: prod_q <= mul_p;
			ST_TM2: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			ST_OUT: pend_q.torque <= out_clamp;
			ST_DONE: begin
				if (load_res) begin
					result_q <= pend_q;
				end
			end
			default: begin
				x_q <= x_q;
			end
		endcase
	end

	assign res_shake_oob = (result.torque > shake_s) || (result.torque < -shake_s);
	assign res_damp_oob  = (result.torque > lim_s) || (result.torque < -lim_s);

	`ASSERT_CLK(a_busy_after_accept, clk, arst_n, accept |=> state_q != ST_IDLE)
	`ASSERT_CLK(a_silent_zero, clk, arst_n, result_valid && !result.torque_write |-> result.torque == '0)
	`ASSERT_NEVER(a_shake_bound, clk, arst_n, result_valid && result.mode_now == MODE_SHAKE && res_shake_oob)
	`ASSERT_NEVER(a_damp_bound, clk, arst_n, result_valid && result.mode_now == MODE_DAMP && res_damp_oob)

endmodule
